FILE: sv/dtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants of the delimited token classifier
// Token kind codes, field widths and the reset value of the separator register.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int POS_W   = 16;  // position and length counters, saturating
    localparam int TOKEN_W = 16;  // start and length fields of a token record
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;

    localparam logic [31:0] SEP_RESET = 32'h2C2F_7C20;

    typedef enum logic [KIND_W-1:0] {
        KIND_END        = 4'd0,
        KIND_BLANK      = 4'd1,
        KIND_NEWLINE    = 4'd2,
        KIND_PUNCT      = 4'd3,
        KIND_QUOTED     = 4'd4,
        KIND_INCOMPLETE = 4'd5,
        KIND_INTEGER    = 4'd6,
        KIND_FLOAT      = 4'd7,
        KIND_WORD       = 4'd8
    } kind_t;

endpackage

FILE: sv/delimited_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_token_classifier: streaming delimiter tokenizer
// Scans text one byte per transaction and emits classified token records.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while s_tready is high:
// each byte updates the scan state and writes zero, one or two token records
// into a four-entry result queue. The input side is ready while the queue has
// room for two records, so the sustained rate is one byte per cycle as long as
// the output side takes one record per cycle; an item that yields two records
// (a token closed by end of text plus the end token, or a newline followed by
// punctuation) writes both records into the queue at once. Records leave from
// the queue head, so a waiting result never blocks the next byte while room remains.
// Write separator_chars only while the stream is idle.
module delimited_token_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data,    // separator_chars

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // [7:0] text_byte
    input  logic                          s_tuser,     // [0] op (1 = end of text)

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,     // [15:0] token_start, [31:16] token_length
    output logic [dtc_pkg::KIND_W-1:0]    m_tuser,     // [3:0] token_kind
    output logic                          m_tlast      // last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WORD  = 3'b010,
        MODE_QUOTE = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        NL_NONE = 2'b00,
        NL_LF   = 2'b01,
        NL_CR   = 2'b10
    } nl_t;

    typedef struct packed {
        dtc_pkg::kind_t                 kind;
        logic [dtc_pkg::TOKEN_W-1:0]    start;
        logic [dtc_pkg::TOKEN_W-1:0]    length;
        logic                           last;
    } res_t;

    localparam logic [dtc_pkg::POS_W-1:0] POS_MAX = {dtc_pkg::POS_W{1'b1}};
    localparam logic [dtc_pkg::POS_W-1:0] POS_ONE = dtc_pkg::POS_W'(1);
    localparam logic [dtc_pkg::POS_W-1:0] POS_TWO = dtc_pkg::POS_W'(2);
    localparam logic [dtc_pkg::POS_W-1:0] POS_ZERO = '0;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic [dtc_pkg::POS_W-1:0] sat_inc(input logic [dtc_pkg::POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic res_t mk_res(input dtc_pkg::kind_t k,
                                    input logic [dtc_pkg::POS_W-1:0] st,
                                    input logic [dtc_pkg::POS_W-1:0] ln);
        res_t r;
        r.kind   = k;
        r.start  = dtc_pkg::TOKEN_W'(st);
        r.length = dtc_pkg::TOKEN_W'(ln);
        r.last   = 1'b0;
        return r;
    endfunction

    logic [31:0]                sep_reg;
    mode_t                      mode_reg, mode_next;
    nl_t                        nl_reg, nl_next;
    logic [dtc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [dtc_pkg::POS_W-1:0]  start_reg, start_next;
    logic [dtc_pkg::POS_W-1:0]  len_reg, len_next;
    logic [1:0]                 dots_reg, dots_next;
    logic                       digits_reg, digits_next;
    logic                       sep_seen_reg, sep_seen_next;

    res_t                       res_q_reg [4];
    logic [1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic [2:0]                 count_reg;

    logic                       in_acc, out_acc;
    logic [7:0]                 b;
    logic                       is_sep, is_nl, is_dec;
    dtc_pkg::kind_t             word_kind;
    res_t                       r0, r1;
    logic [1:0]                 n_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg < 3'd3);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != 3'd0);
    assign out_acc   = m_tvalid && m_tready;

    assign m_tdata   = {res_q_reg[rd_ptr_reg].length, res_q_reg[rd_ptr_reg].start};
    assign m_tuser   = res_q_reg[rd_ptr_reg].kind;
    assign m_tlast   = res_q_reg[rd_ptr_reg].last;

    assign b        = s_tdata;
    assign is_sep   = (sep_reg[7:0] == b) || (sep_reg[15:8] == b) ||
                      (sep_reg[23:16] == b) || (sep_reg[31:24] == b);
    assign is_nl    = (b == CH_LF) || (b == CH_CR);
    assign is_dec   = (b >= CH_ZERO) && (b <= CH_NINE);

    always_comb
    begin
        if (digits_reg && dots_reg == 2'd0)
        begin
            word_kind = dtc_pkg::KIND_INTEGER;
        end
        else if (digits_reg && dots_reg == 2'd1)
        begin
            word_kind = dtc_pkg::KIND_FLOAT;
        end
        else
        begin
            word_kind = dtc_pkg::KIND_WORD;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        nl_next       = nl_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        dots_next     = dots_reg;
        digits_next   = digits_reg;
        sep_seen_next = sep_seen_reg;
        r0            = mk_res(dtc_pkg::KIND_END, pos_reg, POS_ZERO);
        r1            = r0;
        n_res         = 2'd0;

        if (in_acc)
        begin
            if (s_tuser)
            begin
                // close whatever is open, then the end token
                if (mode_reg == MODE_WORD)
                begin
                    r0 = mk_res(word_kind, start_reg, len_reg);
                    n_res = 2'd1;
                end
                else if (mode_reg == MODE_QUOTE)
                begin
                    r0 = mk_res(dtc_pkg::KIND_INCOMPLETE, start_reg, len_reg);
                    n_res = 2'd1;
                end
                else if (nl_reg != NL_NONE)
                begin
                    r0 = mk_res(dtc_pkg::KIND_NEWLINE, start_reg, POS_ONE);
                    n_res = 2'd1;
                end
                else if (sep_seen_reg)
                begin
                    r0 = mk_res(dtc_pkg::KIND_BLANK, pos_reg, POS_ZERO);
                    n_res = 2'd1;
                end
                if (n_res == 2'd1)
                begin
                    r1 = mk_res(dtc_pkg::KIND_END, pos_reg, POS_ZERO);
                    n_res = 2'd2;
                end
                else
                begin
                    r0 = mk_res(dtc_pkg::KIND_END, pos_reg, POS_ZERO);
                    n_res = 2'd1;
                end
                mode_next     = MODE_IDLE;
                nl_next       = NL_NONE;
                pos_next      = '0;
                start_next    = '0;
                len_next      = '0;
                dots_next     = 2'd0;
                digits_next   = 1'b1;
                sep_seen_next = 1'b0;
            end
            else
            begin
                pos_next = sat_inc(pos_reg);
                unique case (mode_reg)
                    MODE_QUOTE:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            r0 = mk_res(dtc_pkg::KIND_QUOTED, start_reg, len_reg);
                            n_res = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            len_next = sat_inc(len_reg);
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_sep)
                        begin
                            r0 = mk_res(word_kind, start_reg, len_reg);
                            n_res = 2'd1;
                            mode_next = MODE_IDLE;
                            sep_seen_next = 1'b1;
                        end
                        else if (is_nl)
                        begin
                            r0 = mk_res(word_kind, start_reg, len_reg);
                            n_res = 2'd1;
                            mode_next = MODE_IDLE;
                            sep_seen_next = 1'b0;
                            nl_next = (b == CH_LF) ? NL_LF : NL_CR;
                            start_next = pos_reg;
                        end
                        else
                        begin
                            len_next = sat_inc(len_reg);
                            if (b == CH_DOT)
                            begin
                                if (dots_reg < 2'd2)
                                begin
                                    dots_next = dots_reg + 2'd1;
                                end
                            end
                            else if (!is_dec)
                            begin
                                digits_next = 1'b0;
                            end
                        end
                    end
                    MODE_IDLE:
                    begin
                        // a pending newline either pairs with this byte or goes out alone
                        if ((nl_reg == NL_LF && b == CH_CR) || (nl_reg == NL_CR && b == CH_LF))
                        begin
                            r0 = mk_res(dtc_pkg::KIND_NEWLINE, start_reg, POS_TWO);
                            n_res = 2'd1;
                            nl_next = NL_NONE;
                        end
                        else
                        begin
                            if (nl_reg != NL_NONE)
                            begin
                                r0 = mk_res(dtc_pkg::KIND_NEWLINE, start_reg, POS_ONE);
                                n_res = 2'd1;
                                nl_next = NL_NONE;
                            end
                            if (is_sep)
                            begin
                                sep_seen_next = 1'b1;
                            end
                            else
                            begin
                                sep_seen_next = 1'b0;
                                if (is_nl)
                                begin
                                    nl_next = (b == CH_LF) ? NL_LF : NL_CR;
                                    start_next = pos_reg;
                                end
                                else if (b == CH_COLON || b == CH_EQUAL || b == CH_SEMI)
                                begin
                                    if (n_res == 2'd0)
                                    begin
                                        r0 = mk_res(dtc_pkg::KIND_PUNCT, pos_reg, POS_ONE);
                                        n_res = 2'd1;
                                    end
                                    else
                                    begin
                                        r1 = mk_res(dtc_pkg::KIND_PUNCT, pos_reg, POS_ONE);
                                        n_res = 2'd2;
                                    end
                                end
                                else if (b == CH_QUOTE)
                                begin
                                    mode_next = MODE_QUOTE;
                                    start_next = sat_inc(pos_reg);
                                    len_next = '0;
                                end
                                else
                                begin
                                    mode_next = MODE_WORD;
                                    start_next = pos_reg;
                                    len_next = POS_ONE;
                                    dots_next = (b == CH_DOT) ? 2'd1 : 2'd0;
                                    digits_next = (b == CH_DOT) || is_dec;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end

        if (n_res == 2'd1)
        begin
            r0.last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg      <= dtc_pkg::SEP_RESET;
            mode_reg     <= MODE_IDLE;
            nl_reg       <= NL_NONE;
            pos_reg      <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            dots_reg     <= 2'd0;
            digits_reg   <= 1'b1;
            sep_seen_reg <= 1'b0;
            wr_ptr_reg   <= 2'd0;
            rd_ptr_reg   <= 2'd0;
            count_reg    <= 3'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sep_reg <= cfg_data;
            end
            mode_reg     <= mode_next;
            nl_reg       <= nl_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            dots_reg     <= dots_next;
            digits_reg   <= digits_next;
            sep_seen_reg <= sep_seen_next;
            wr_ptr_reg   <= wr_ptr_reg + n_res;
            if (out_acc)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, n_res} - {2'b00, out_acc};
        end
    end

    // result queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            res_q_reg[wr_ptr_reg] <= r0;
        end
        if (n_res == 2'd2)
        begin
            res_q_reg[wr_ptr_reg + 2'd1] <= r1;
        end
    end

endmodule

FILE: sv/dtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_checker: port-level checks of the delimited token classifier
// Watches the result stream and flags malformed token records.
// ----------------------------------------------------------------------------
module dtc_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [31:0]                m_tdata,
    input logic [dtc_pkg::KIND_W-1:0] m_tuser,
    input logic                       m_tlast
);

    // a stalled record holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled token record changed");

    // the end token always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == dtc_pkg::KIND_END |-> m_tlast && m_tdata[31:16] == 16'd0)
    else $error("end token not last or nonzero length");

    // a blank token is not last in its run (the end token follows) and has zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == dtc_pkg::KIND_BLANK |->
            !m_tlast && m_tdata[31:16] == 16'd0)
    else $error("blank token malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == dtc_pkg::KIND_PUNCT |-> m_tdata[31:16] == 16'd1)
    else $error("punctuation token length not one");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == dtc_pkg::KIND_NEWLINE |->
            m_tdata[31:16] == 16'd1 || m_tdata[31:16] == 16'd2)
    else $error("newline token length out of range");

endmodule

bind delimited_token_classifier dtc_checker u_dtc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
